### design/bb_pkg.sv
// ----------------------------------------------------------------------------
// bb_pkg
// Types, constants and helpers shared by the 3x3 box blur block.
// ----------------------------------------------------------------------------
package bb_pkg;

    localparam int ROW_W    = 11;
    localparam int ROWS_MAX = 2048;
    localparam int OQ_DEPTH = 8;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
    localparam int RCP_W    = 18;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_bb_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
        logic       run_last;
    } t_bb_out;

    // channel 2 red, 1 green, 0 blue
    typedef logic [2:0][7:0] t_bb_rgb;

    typedef struct packed {
        logic       valid;
        logic       rd;
        logic       wr;
        logic       first;
        logic       va;
        logic       vb;
        logic       vc;
        logic       emit;
        logic       frame_end;
        logic       run_last;
        t_bb_rgb    pixel;
    } t_bb_op;

    typedef struct packed {
        logic [2:0][9:0] sum;
        logic [1:0]      cnt;
    } t_bb_col;

    typedef enum logic [1:0] {
        SQ_RUN,
        SQ_FLUSH,
        SQ_PRE,
        SQ_TAIL
    } t_bb_seq_state;

    // ceil(2^18 / (2*cnt)), exact for every in-frame window count
    function automatic logic [RCP_W-1:0] bb_recip(input logic [3:0] cnt);
        logic [RCP_W-1:0] m;
        case (cnt)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd0;
        endcase
        return m;
    endfunction

endpackage

### design/box_blur_3x3_edge_aware.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// Edge aware 3x3 box blur over a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels stream in at one transaction per clock while the sequencer runs and
// the result queue has credit. A pixel that ends a row with results due (any
// row but the first of a taller frame) is followed by a flush state, in which
// the right-edge window is formed. After the last pixel of a taller frame a
// prefetch state reads the bottom rows at column 0, and a one-column frame then
// forms its last result in the tail state. Each later transaction (drain, or a
// pixel that is dropped) then yields two results in the tail state, or one
// when only one is left. The limit is the single line RAM (two rows of 24-bit
// pixels in one 48-bit word per column, MAX_WIDTH deep), read and written once
// per cycle, plus an 8-entry result queue. The RAM needs no clearing after reset.
module box_blur_3x3_edge_aware import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_bb_in      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_bb_out     o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic [11:0]       r_frame_width, r_frame_height;
    logic [ADDR_W-1:0] w_m1;
    logic [ROW_W-1:0]  h_m1;
    t_bb_op            op;
    logic [ADDR_W-1:0] op_addr;
    logic              push, oq_full, pop;
    t_bb_out           push_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 12'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == 12'd0) begin
            w_m1 = '0;
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_m1 = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = ADDR_W'(r_frame_width - 12'd1);
        end
        if (r_frame_height == 12'd0) begin
            h_m1 = '0;
        end else if (32'(r_frame_height) > 32'(ROWS_MAX)) begin
            h_m1 = ROW_W'(ROWS_MAX - 1);
        end else begin
            h_m1 = ROW_W'(r_frame_height - 12'd1);
        end
    end

    assign pop = o_out_valid && i_out_ready;

    bb_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_w_m1   (w_m1),
        .i_h_m1   (h_m1),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_ready  (o_in_ready),
        .i_pop    (pop),
        .o_op     (op),
        .o_addr   (op_addr)
    );

    bb_win #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_addr      (op_addr),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bb_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_ready     (i_out_ready),
        .o_full      (oq_full)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !oq_full)
        else $error("result queue overflow");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_end |-> o_out_data.run_last)
        else $error("frame end not on last result of transaction");

    a_ready_needs_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && oq_full |-> !op.emit)
        else $error("window issued with full queue");
`endif

endmodule

### design/bb_ram.sv
// ----------------------------------------------------------------------------
// bb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/bb_seq.sv
// ----------------------------------------------------------------------------
// bb_seq
// Frame position tracking and op sequencer for the line RAM and window.
// ----------------------------------------------------------------------------
module bb_seq import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int ADDR_W   = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_w_m1,
    input  logic [ROW_W-1:0]  i_h_m1,
    input  logic              i_valid,
    input  t_bb_in            i_data,
    output logic              o_ready,
    input  logic              i_pop,
    output t_bb_op            o_op,
    output logic [ADDR_W-1:0] o_addr
);

    t_bb_seq_state     r_state, n_state;
    logic [ADDR_W-1:0] r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic              r_tail, n_tail;
    logic [ADDR_W-1:0] r_tail_k, n_tail_k;
    logic              r_two, n_two;
    logic              r_flast, n_flast;
    logic [OQ_CW-1:0]  r_credit, n_credit;

    logic accept, emitting, row_end, tail_last, tall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SQ_RUN;
            r_in_col <= '0;
            r_in_row <= '0;
            r_tail   <= 1'b0;
            r_tail_k <= '0;
            r_two    <= 1'b0;
            r_flast  <= 1'b0;
            r_credit <= OQ_CW'(OQ_DEPTH);
        end else begin
            r_state  <= n_state;
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_tail   <= n_tail;
            r_tail_k <= n_tail_k;
            r_two    <= n_two;
            r_flast  <= n_flast;
            r_credit <= n_credit;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_tail   = r_tail;
        n_tail_k = r_tail_k;
        n_two    = r_two;
        n_flast  = r_flast;
        o_op     = '0;
        o_addr   = '0;

        tall      = (i_h_m1 != '0);
        o_ready   = (r_state == SQ_RUN) && (r_credit != '0);
        accept    = i_valid && o_ready;
        emitting  = (r_in_row != '0) || !tall;
        row_end   = (r_in_col == i_w_m1);
        tail_last = (r_tail_k == i_w_m1);

        case (r_state)
            SQ_RUN: begin
                if (accept) begin
                    if (r_tail) begin
                        n_state = SQ_TAIL;
                        n_two   = 1'b1;
                    end else if (i_data.kind == KIND_PIXEL) begin
                        o_op.valid    = 1'b1;
                        o_op.rd       = 1'b1;
                        o_op.wr       = 1'b1;
                        o_addr        = r_in_col;
                        o_op.pixel    = {i_data.red_in, i_data.green_in, i_data.blue_in};
                        o_op.first    = (r_in_col == '0);
                        o_op.va       = (r_in_row > ROW_W'(1));
                        o_op.vb       = (r_in_row != '0);
                        o_op.vc       = 1'b1;
                        o_op.emit     = emitting && (r_in_col != '0);
                        o_op.run_last = emitting && (r_in_col != '0) && !row_end;
                        if (row_end) begin
                            n_in_col = '0;
                            if (r_in_row == i_h_m1) begin
                                n_in_row = '0;
                                n_tail   = tall;
                            end else begin
                                n_in_row = r_in_row + ROW_W'(1);
                            end
                            if (emitting) begin
                                n_state = SQ_FLUSH;
                                n_flast = (r_in_row == i_h_m1);
                            end
                        end else begin
                            n_in_col = r_in_col + ADDR_W'(1);
                        end
                    end
                end
            end
            SQ_FLUSH: begin
                if (r_credit != '0) begin
                    o_op.valid     = 1'b1;
                    o_op.emit      = 1'b1;
                    o_op.frame_end = r_flast && !tall;
                    o_op.run_last  = !(r_flast && tall && (i_w_m1 == '0));
                    n_state        = (r_flast && tall) ? SQ_PRE : SQ_RUN;
                end
            end
            SQ_PRE: begin
                o_op.valid = 1'b1;
                o_op.rd    = 1'b1;
                o_op.first = 1'b1;
                o_op.va    = 1'b1;
                o_op.vb    = 1'b1;
                o_addr     = '0;
                n_tail_k   = '0;
                if (i_w_m1 == '0) begin
                    n_state = SQ_TAIL;
                    n_two   = 1'b0;
                end else begin
                    n_state = SQ_RUN;
                end
            end
            SQ_TAIL: begin
                if (r_credit != '0) begin
                    o_op.valid     = 1'b1;
                    o_op.va        = !tail_last;
                    o_op.vb        = !tail_last;
                    o_op.emit      = 1'b1;
                    o_op.rd        = !tail_last;
                    o_addr         = tail_last ? '0 : r_tail_k + ADDR_W'(1);
                    o_op.frame_end = tail_last;
                    o_op.run_last  = tail_last || !r_two;
                    if (tail_last) begin
                        n_tail  = 1'b0;
                        n_state = SQ_RUN;
                    end else begin
                        n_tail_k = r_tail_k + ADDR_W'(1);
                        if (r_two) begin
                            n_two = 1'b0;
                        end else begin
                            n_state = SQ_RUN;
                        end
                    end
                end
            end
            default: begin
                n_state = SQ_RUN;
            end
        endcase

        if (i_cfg_we) begin
            n_state  = SQ_RUN;
            n_in_col = '0;
            n_in_row = '0;
            n_tail   = 1'b0;
        end

        n_credit = r_credit - OQ_CW'(o_op.valid && o_op.emit) + OQ_CW'(i_pop);
    end

endmodule

### design/bb_win.sv
// ----------------------------------------------------------------------------
// bb_win
// Line RAM access, column history, window sums and rounded mean.
// ----------------------------------------------------------------------------
module bb_win import bb_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    localparam int ADDR_W   = $clog2(MAX_WIDTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bb_op            i_op,
    input  logic [ADDR_W-1:0] i_addr,
    output logic              o_push,
    output t_bb_out           o_push_data
);

    t_bb_op            r_op;
    logic [ADDR_W-1:0] r_addr;
    logic              r_byp_hit;
    logic [47:0]       r_byp_data;
    logic [47:0]       ram_rdata, col_data, wdata;
    logic              we;
    t_bb_rgb           pa, pb;
    t_bb_col           col;

    t_bb_col           r_h0, r_h1, r_h2;
    logic              r_s2_emit, r_s2_fe, r_s2_rl;

    logic [2:0][12:0]  x;
    logic [3:0]        cnt;
    logic [2:0][12:0]  r_x;
    logic [RCP_W-1:0]  r_m;
    logic              r_s3_emit, r_s3_fe, r_s3_rl;
    logic [30:0]       prod [3];

    // stage 1: line ram read data and write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op.valid <= 1'b0;
            r_byp_hit  <= 1'b0;
        end else begin
            r_op.valid <= i_op.valid;
            r_byp_hit  <= i_op.valid && i_op.rd && we && (i_addr == r_addr);
        end
        r_op.rd        <= i_op.rd;
        r_op.wr        <= i_op.wr;
        r_op.first     <= i_op.first;
        r_op.va        <= i_op.va;
        r_op.vb        <= i_op.vb;
        r_op.vc        <= i_op.vc;
        r_op.emit      <= i_op.emit;
        r_op.frame_end <= i_op.frame_end;
        r_op.run_last  <= i_op.run_last;
        r_op.pixel     <= i_op.pixel;
        r_addr         <= i_addr;
        r_byp_data     <= wdata;
    end

    assign col_data = r_byp_hit ? r_byp_data : ram_rdata;
    assign pa       = col_data[47:24];
    assign pb       = col_data[23:0];
    assign we       = r_op.valid && r_op.wr;
    assign wdata    = {pb, r_op.pixel};

    bb_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_re    (i_op.valid && i_op.rd),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            col.sum[ch] = (r_op.va ? 10'(pa[ch]) : 10'd0)
                        + (r_op.vb ? 10'(pb[ch]) : 10'd0)
                        + (r_op.vc ? 10'(r_op.pixel[ch]) : 10'd0);
        end
        col.cnt = 2'(r_op.va) + 2'(r_op.vb) + 2'(r_op.vc);
    end

    // stage 2: column history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_op.valid && r_op.emit;
        end
        r_s2_fe <= r_op.frame_end;
        r_s2_rl <= r_op.run_last;
        if (r_op.valid) begin
            r_h0 <= col;
            r_h1 <= r_op.first ? '0 : r_h0;
            r_h2 <= r_h1;
        end
    end

    always_comb begin
        cnt = 4'(r_h0.cnt) + 4'(r_h1.cnt) + 4'(r_h2.cnt);
        for (int ch = 0; ch < 3; ch++) begin
            x[ch] = {12'(r_h0.sum[ch]) + 12'(r_h1.sum[ch]) + 12'(r_h2.sum[ch]), 1'b0}
                  + 13'(cnt);
        end
    end

    // stage 3: reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_emit <= 1'b0;
        end else begin
            r_s3_emit <= r_s2_emit;
        end
        r_s3_fe <= r_s2_fe;
        r_s3_rl <= r_s2_rl;
        r_x     <= x;
        r_m     <= bb_recip(cnt);
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = 31'(r_x[ch]) * 31'(r_m);
        end
        o_push                = r_s3_emit;
        o_push_data.red_out   = prod[2][RCP_W+7:RCP_W];
        o_push_data.green_out = prod[1][RCP_W+7:RCP_W];
        o_push_data.blue_out  = prod[0][RCP_W+7:RCP_W];
        o_push_data.frame_end = r_s3_fe;
        o_push_data.run_last  = r_s3_rl;
    end

endmodule

### design/bb_outq.sv
// ----------------------------------------------------------------------------
// bb_outq
// Small output queue between the mean pipeline and the result channel.
// ----------------------------------------------------------------------------
module bb_outq import bb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bb_out i_push_data,
    output logic    o_valid,
    output t_bb_out o_data,
    input  logic    i_ready,
    output logic    o_full
);

    t_bb_out          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_CW-1:0] r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == OQ_CW'(OQ_DEPTH));
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_rp + OQ_AW'(1);
            end
            r_cnt <= r_cnt + OQ_CW'(i_push) - OQ_CW'(pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule
